/* hdl/otb_pkg.sv */
// shared types, constants and the control store for the one-shot timer bank
// no dependencies; imported by otb_seq and one_shot_timer_bank
package otb_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int NEXP_W      = 7;
  localparam int SLOT_W      = 6;
  localparam int STEP_W      = 3;

  // request modes
  localparam logic [1:0] MODE_ARM     = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_SERVICE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ARM_ACK = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // program steps
  localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ARM      = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TICK     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TICK_END = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SERVICE  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_NONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [31:0] load_count;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
    logic [NEXP_W-1:0] newly_expired;
    logic              last;
  } rsp_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ARM,
    ACT_TICK,
    ACT_SERVICE
  } act_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ARM,
    EM_TICK,
    EM_SLOT,
    EM_NONE_EXP
  } emit_t;

  typedef enum logic [1:0] {
    C_INPUT,
    C_ALWAYS,
    C_WALK,
    C_SCAN
  } cond_t;

  typedef struct packed {
    act_t              act;
    emit_t             emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic       req_valid;
    logic [1:0] mode;
    logic       go;
    logic       idx_last;
    logic       done_early;
  } stat_t;

  // control word handed to the datapath
  typedef struct packed {
    act_t  act;
    emit_t emit;
    logic  idle;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_IDLE:     w = '{ACT_NONE,    EM_NONE,     C_INPUT,  STEP_IDLE};
      STEP_ARM:      w = '{ACT_ARM,     EM_ARM,      C_ALWAYS, STEP_IDLE};
      STEP_TICK:     w = '{ACT_TICK,    EM_NONE,     C_WALK,   STEP_TICK_END};
      STEP_TICK_END: w = '{ACT_NONE,    EM_TICK,     C_ALWAYS, STEP_IDLE};
      STEP_SERVICE:  w = '{ACT_SERVICE, EM_SLOT,     C_SCAN,   STEP_NONE};
      STEP_NONE:     w = '{ACT_NONE,    EM_NONE_EXP, C_ALWAYS, STEP_IDLE};
      default:       w = '{ACT_NONE,    EM_NONE,     C_INPUT,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/otb_seq.sv */
// step counter, control store lookup and jump logic for the timer bank
// depends on otb_pkg
module otb_seq import otb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            word;

  assign word = ucode_rom(step);
  assign ctrl = {word.act, word.emit, (word.cond == C_INPUT)};

  always_comb begin
    step_next = step;
    case (word.cond)
      C_INPUT: begin
        if (stat.req_valid) begin
          case (stat.mode)
            MODE_ARM:     step_next = STEP_ARM;
            MODE_TICK:    step_next = STEP_TICK;
            MODE_SERVICE: step_next = STEP_SERVICE;
            default:      step_next = STEP_IDLE;
          endcase
        end
      end
      C_ALWAYS: begin
        if (stat.go) step_next = word.target;
      end
      C_WALK: begin
        if (stat.go && stat.idx_last) step_next = word.target;
      end
      C_SCAN: begin
        // last expired slot reported: done; walked off the end: nothing found
        if (stat.go && stat.done_early) step_next = STEP_IDLE;
        else if (stat.go && stat.idx_last) step_next = word.target;
      end
      default: step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* hdl/one_shot_timer_bank.sv */
// A bank of TIMER_COUNT one-shot countdown timers run by a small microcoded
// sequencer that walks the timer slots one per cycle. An arm request is first
// accepted and then carried out in the arm step; a tick walks every slot, and
// each filled slot's nonzero count is read, decremented and written back; a
// service request stops at the last expired slot or reports none found. A full
// result register decouples the output: a new request is taken while a result
// still waits, and the walk only pauses when it has a result to hand over and
// the register is still occupied. The slot flags, index, expiry count and
// result valid flag are clear after reset, and the block is ready at once.
// depends on otb_pkg and otb_seq
module one_shot_timer_bank import otb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [COUNT_WIDTH-1:0] remaining [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] filled;
  logic [TIMER_COUNT-1:0] expired;
  logic [IDX_W-1:0]       idx;
  logic [NEXP_W-1:0]      nexp;
  req_t                   item;

  stat_t stat;
  ctrl_t ctrl;

  logic                   accept;
  logic                   out_free;
  logic                   idx_last;
  logic                   any_above;
  logic                   arm_ok;
  logic [IDX_W-1:0]       arm_idx;
  logic [COUNT_WIDTH-1:0] rem_cur;
  logic                   emit_now;
  logic                   go;
  rsp_t                   rsp_next;

  otb_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign req_ready = ctrl.idle;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign idx_last  = (idx == IDX_W'(TIMER_COUNT - 1));
  assign arm_idx   = item.timer_id[IDX_W-1:0];
  assign arm_ok    = (item.timer_id < 8'(TIMER_COUNT)) && !filled[arm_idx];
  assign rem_cur   = remaining[idx];

  // any expired slot beyond the current one decides the last mark
  always_comb begin
    any_above = 1'b0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (expired[i] && (i > int'(idx))) any_above = 1'b1;
    end
  end

  always_comb begin
    case (ctrl.emit)
      EM_NONE: go = 1'b1;
      EM_SLOT: go = !expired[idx] || out_free;
      default: go = out_free;
    endcase
  end

  assign stat = {req_valid, req.mode, go, idx_last, (expired[idx] && !any_above)};

  always_comb begin
    emit_now = 1'b0;
    rsp_next = '0;
    case (ctrl.emit)
      EM_ARM: begin
        emit_now          = out_free;
        rsp_next.kind     = KIND_ARM_ACK;
        rsp_next.accepted = arm_ok;
        rsp_next.last     = 1'b1;
      end
      EM_TICK: begin
        emit_now               = out_free;
        rsp_next.kind          = KIND_TICK;
        rsp_next.newly_expired = nexp;
        rsp_next.last          = 1'b1;
      end
      EM_SLOT: begin
        emit_now      = out_free && expired[idx];
        rsp_next.kind = KIND_EXPIRED;
        rsp_next.slot = SLOT_W'(idx);
        rsp_next.last = !any_above;
      end
      EM_NONE_EXP: begin
        emit_now      = out_free;
        rsp_next.kind = KIND_NONE;
        rsp_next.last = 1'b1;
      end
      default: begin
        emit_now = 1'b0;
      end
    endcase
  end

  // count store needs no reset: a count is only read while its slot is filled
  always_ff @(posedge clk) begin
    if (accept) item <= req;
    case (ctrl.act)
      ACT_ARM: begin
        if (arm_ok && stat.go) remaining[arm_idx] <= item.load_count[COUNT_WIDTH-1:0];
      end
      ACT_TICK: begin
        if (filled[idx] && (rem_cur != '0)) remaining[idx] <= rem_cur - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled  <= '0;
      expired <= '0;
      idx     <= '0;
      nexp    <= '0;
    end else if (accept) begin
      idx  <= '0;
      nexp <= '0;
    end else begin
      case (ctrl.act)
        ACT_ARM: begin
          if (arm_ok && stat.go) begin
            filled[arm_idx]  <= 1'b1;
            expired[arm_idx] <= 1'b0;
          end
        end
        ACT_TICK: begin
          if (filled[idx] && (rem_cur == COUNT_WIDTH'(1))) begin
            filled[idx]  <= 1'b0;
            expired[idx] <= 1'b1;
            nexp         <= nexp + 1'b1;
          end
          idx <= idx_last ? '0 : idx + 1'b1;
        end
        ACT_SERVICE: begin
          if (stat.go) begin
            expired[idx] <= 1'b0;
            idx          <= idx_last ? '0 : idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_now) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) rsp <= rsp_next;
  end

  a_filled_expired_disjoint: assert property (@(posedge clk) disable iff (rst)
    (filled & expired) == '0)
    else $error("slot both filled and expired");

  a_arm_fills: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_ARM && stat.go && arm_ok) |=> filled[$past(arm_idx)])
    else $error("accepted arm did not fill its slot");

  a_last_report_ends: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_SERVICE && stat.go && stat.done_early) |=> req_ready)
    else $error("service walk continued past its last report");

  a_nexp_bound: assert property (@(posedge clk) disable iff (rst)
    nexp <= NEXP_W'(TIMER_COUNT))
    else $error("expiry count beyond bank size");

endmodule
